// ----- src/rgba_density_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// RGBA density accumulator assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RGBA_DENSITY_ACCUMULATOR_DEFINES_SVH
`define RGBA_DENSITY_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rda: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rda: next-cycle check failed");

// State right after a reset edge.
`define RDA_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("rda: reset state check failed");

`endif

// ----- src/rda_pkg.sv -----
// ----------------------------------------------------------------------------
// RGBA density accumulator package
// Word types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package rda_pkg;

    localparam int CH_BITS       = 16;
    localparam int PROD_W        = 2 * CH_BITS;
    localparam int FRAC_BITS     = 16;
    localparam int REF_BITS      = 16;
    localparam int LANES         = 4;
    localparam int WHOLE_REG_W   = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_WHOLE_DEF = 16;

    localparam logic [CH_BITS-1:0]   CH_ONE    = '1;
    localparam logic [PROD_W-1:0]    CH_HALF   = PROD_W'(CH_ONE >> 1);
    localparam logic [FRAC_BITS:0]   FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [REF_BITS-1:0]  REF_ONE   = '1;
    localparam logic [REF_BITS-1:0]  REF_HALF  = REF_ONE >> 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DENSITY_WHOLE    = 2'd0,
        CFG_DENSITY_FRACTION = 2'd1,
        CFG_REF_ENABLE       = 2'd2
    } t_cfg_idx;

    typedef logic [CH_BITS-1:0] t_chan;
    typedef t_chan [LANES-1:0] t_lanes;
    typedef logic [LANES-1:0][PROD_W-1:0] t_prods;

    typedef struct packed {
        t_chan               red_in;
        t_chan               green_in;
        t_chan               blue_in;
        t_chan               alpha_in;
        logic [REF_BITS-1:0] ref_weight;
        logic                last_pixel;
    } t_in;

    typedef struct packed {
        t_chan red_out;
        t_chan green_out;
        t_chan blue_out;
        t_chan alpha_out;
        logic  last_pixel_out;
    } t_out;

    // Pixel in flight: lane 0 red, 1 green, 2 blue, 3 alpha.
    typedef struct packed {
        t_lanes              v;
        t_lanes              acc;
        t_lanes              nxt;
        t_chan               t;
        logic [REF_BITS-1:0] w;
        logic                last;
    } t_item;

    // floor(x / CH_ONE): x = h*2^B + l = h*CH_ONE + (h + l), and h + l <= 2*CH_ONE.
    function automatic logic [CH_BITS:0] div_ones(input logic [PROD_W-1:0] x);
        logic [CH_BITS-1:0] h;
        logic [CH_BITS-1:0] l;
        logic [CH_BITS:0]   s;
        logic [1:0]         q;
        h = x[PROD_W-1:CH_BITS];
        l = x[CH_BITS-1:0];
        s = {1'b0, h} + {1'b0, l};
        if (s >= {CH_ONE, 1'b0}) begin
            q = 2'd2;
        end else if (s >= {1'b0, CH_ONE}) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return {1'b0, h} + {{(CH_BITS-1){1'b0}}, q};
    endfunction

    function automatic t_chan sat_chan(input logic [CH_BITS+1:0] x);
        return (x > {2'b00, CH_ONE}) ? CH_ONE : x[CH_BITS-1:0];
    endfunction

    // One layer: round(acc*t / ONE) + v, saturated at ONE.
    function automatic t_chan layer_step(input t_chan v, input logic [PROD_W-1:0] prod);
        logic [CH_BITS:0]   q;
        logic [CH_BITS+1:0] n;
        q = div_ones(prod + CH_HALF);
        n = {1'b0, q} + {2'b00, v};
        return sat_chan(n);
    endfunction

endpackage

// ----- src/rgba_density_accumulator.sv -----
// ----------------------------------------------------------------------------
// RGBA density accumulator
// Layers each premultiplied pixel onto itself by a programmable density.
// Input channel: i_in_valid / o_in_ready carry one pixel word (RGBA 0.16,
// reference weight, last-pixel flag). Output channel: o_out_valid /
// i_out_ready carry one adjusted word per input word, in order.
// Configuration: i_cfg_we writes density_whole (0), density_fraction (1) or
// ref_enable (2) at once; write only while no word is in flight.
// Throughput: one word per cycle while the skid entry is free. The pipeline
// holds a capture stage, one multiply stage and one reduce stage per density
// layer, two for the fractional layer and a products stage for the reference
// blend, whose sum is taken into the output register.
// Reset (synchronous, active low): flushes the pipeline, clears the output
// register and skid entry, and loads density 1.0 with the blend off.
// Receiver stall: the word holds on o_out_data; the next finished word drops
// into a skid entry, and only while that entry is full does the whole
// pipeline hold and o_in_ready go low. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgba_density_accumulator #(
    parameter int MAX_WHOLE = rda_pkg::MAX_WHOLE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rda_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rda_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [rda_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rda_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int WHOLE_W = $clog2(MAX_WHOLE + 1);
    localparam int CMP_W   = WHOLE_W + rda_pkg::WHOLE_REG_W;
    localparam int LANES   = rda_pkg::LANES;
    localparam int PROD_W  = rda_pkg::PROD_W;
    localparam int CH_BITS = rda_pkg::CH_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rda_pkg::WHOLE_REG_W-1:0] r_density_whole;
    logic [rda_pkg::FRAC_BITS-1:0]   r_density_fraction;
    logic                            r_ref_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density_whole    <= rda_pkg::WHOLE_REG_W'(1);
            r_density_fraction <= '0;
            r_ref_enable       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rda_pkg::CFG_DENSITY_WHOLE: begin
                    r_density_whole <= i_cfg_data[rda_pkg::WHOLE_REG_W-1:0];
                end
                rda_pkg::CFG_DENSITY_FRACTION: begin
                    r_density_fraction <= i_cfg_data[rda_pkg::FRAC_BITS-1:0];
                end
                rda_pkg::CFG_REF_ENABLE: begin
                    r_ref_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Whole part above the pipeline depth counts as the full depth.
    logic [WHOLE_W-1:0] w_whole;
    assign w_whole = (CMP_W'(r_density_whole) > CMP_W'(MAX_WHOLE)) ?
                     WHOLE_W'(MAX_WHOLE) : WHOLE_W'(r_density_whole);

    // ------------------------------------------------------------------
    // Flow control: the pipeline advances as one while the skid entry is free
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_skid_valid;
    logic w_adv;

    assign w_adv      = !r_skid_valid;
    assign o_in_ready = w_adv;

    // ------------------------------------------------------------------
    // Capture stage: unpack the word, acc starts at v
    // ------------------------------------------------------------------
    logic          r_lv [0:MAX_WHOLE];
    rda_pkg::t_item r_li [0:MAX_WHOLE];
    logic          r_mv [1:MAX_WHOLE];
    rda_pkg::t_item r_mi [1:MAX_WHOLE];
    rda_pkg::t_prods r_mp [1:MAX_WHOLE];

    rda_pkg::t_item n_cap;

    always_comb begin
        n_cap.v[0] = i_in_data.red_in;
        n_cap.v[1] = i_in_data.green_in;
        n_cap.v[2] = i_in_data.blue_in;
        n_cap.v[3] = i_in_data.alpha_in;
        n_cap.acc  = n_cap.v;
        n_cap.nxt  = n_cap.v;
        n_cap.t    = rda_pkg::CH_ONE - i_in_data.alpha_in;
        n_cap.w    = i_in_data.ref_weight;
        n_cap.last = i_in_data.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= 1'b0;
        end else if (w_adv) begin
            r_lv[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_li[0] <= n_cap;
        end
    end

    // ------------------------------------------------------------------
    // Layer k: multiply acc*t, then reduce by ONE, add v and saturate.
    // Layers below the whole part update acc; the layer at the whole part
    // lands in nxt for the fractional blend; later layers pass through.
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= MAX_WHOLE; k++) begin : g_layer
        localparam logic [WHOLE_W-1:0] LAYER = WHOLE_W'(k);

        rda_pkg::t_item n_ri;
        rda_pkg::t_lanes n_layer;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[k] <= 1'b0;
            end else if (w_adv) begin
                r_mv[k] <= r_lv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mi[k] <= r_li[k-1];
                for (int j = 0; j < LANES; j++) begin
                    r_mp[k][j] <= PROD_W'(r_li[k-1].acc[j]) * PROD_W'(r_li[k-1].t);
                end
            end
        end

        always_comb begin
            n_ri = r_mi[k];
            for (int j = 0; j < LANES; j++) begin
                n_layer[j] = rda_pkg::layer_step(r_mi[k].v[j], r_mp[k][j]);
                if (LAYER < w_whole) begin
                    n_ri.acc[j] = n_layer[j];
                end
                if (LAYER == w_whole) begin
                    n_ri.nxt[j] = n_layer[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[k] <= 1'b0;
            end else if (w_adv) begin
                r_lv[k] <= r_mv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_li[k] <= n_ri;
            end
        end
    end

    // ------------------------------------------------------------------
    // Fractional layer, products: acc*(1-f) and next*f.
    // Zero whole part: acc = 0 and next = v, which gives v*f rounded,
    // and 0 when f is also 0.
    // ------------------------------------------------------------------
    logic                              r_fv;
    rda_pkg::t_item                    r_fi;
    logic [LANES-1:0][PROD_W:0]        r_fa;
    rda_pkg::t_prods                   r_fb;

    logic                              n_zero;
    rda_pkg::t_lanes                   n_base;
    rda_pkg::t_lanes                   n_top;
    logic [LANES-1:0][PROD_W:0]        n_fa;
    rda_pkg::t_prods                   n_fb;

    always_comb begin
        n_zero = (w_whole == '0);
        for (int j = 0; j < LANES; j++) begin
            n_base[j] = n_zero ? '0 : r_li[MAX_WHOLE].acc[j];
            n_top[j]  = n_zero ? r_li[MAX_WHOLE].v[j] : r_li[MAX_WHOLE].nxt[j];
            n_fa[j]   = (PROD_W+1)'(n_base[j]) *
                        (PROD_W+1)'(rda_pkg::FRAC_ONE - {1'b0, r_density_fraction});
            n_fb[j]   = PROD_W'(n_top[j]) * PROD_W'(r_density_fraction);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_adv) begin
            r_fv <= r_lv[MAX_WHOLE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fi <= r_li[MAX_WHOLE];
            r_fa <= n_fa;
            r_fb <= n_fb;
        end
    end

    // ------------------------------------------------------------------
    // Fractional layer, sum: round to 0.16 and clamp
    // ------------------------------------------------------------------
    logic                         r_gv;
    rda_pkg::t_item               r_gi;
    logic [LANES-1:0][PROD_W+1:0] n_bsum;
    rda_pkg::t_item               n_gi;

    always_comb begin
        n_gi = r_fi;
        for (int j = 0; j < LANES; j++) begin
            n_bsum[j]   = (PROD_W+2)'(r_fa[j]) + (PROD_W+2)'(r_fb[j]) +
                          (PROD_W+2)'(rda_pkg::FRAC_HALF);
            n_gi.acc[j] = rda_pkg::sat_chan(n_bsum[j][rda_pkg::FRAC_BITS +: CH_BITS+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (w_adv) begin
            r_gv <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gi <= n_gi;
        end
    end

    // ------------------------------------------------------------------
    // Reference blend, products: v*(1-r) and acc*r
    // ------------------------------------------------------------------
    logic            r_hv;
    rda_pkg::t_item  r_hi;
    rda_pkg::t_prods r_ha;
    rda_pkg::t_prods r_hb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (w_adv) begin
            r_hv <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hi <= r_gi;
            for (int j = 0; j < LANES; j++) begin
                r_ha[j] <= PROD_W'(r_gi.v[j]) * PROD_W'(rda_pkg::REF_ONE - r_gi.w);
                r_hb[j] <= PROD_W'(r_gi.acc[j]) * PROD_W'(r_gi.w);
            end
        end
    end

    // ------------------------------------------------------------------
    // Reference blend, sum: round, divide by the weight's 1.0 and clamp.
    // The weight's 1.0 and the channel's 1.0 are the same 16-bit code, so
    // the channel divider serves here too.
    // ------------------------------------------------------------------
    logic [LANES-1:0][PROD_W:0] n_rsum;
    rda_pkg::t_lanes            n_res;
    rda_pkg::t_out              n_out;
    logic                       n_emit;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_rsum[j] = (PROD_W+1)'(r_ha[j]) + (PROD_W+1)'(r_hb[j]) +
                        (PROD_W+1)'(rda_pkg::REF_HALF);
            n_res[j]  = r_ref_enable ?
                        rda_pkg::sat_chan({1'b0, rda_pkg::div_ones(n_rsum[j][PROD_W-1:0])}) :
                        r_hi.acc[j];
        end
        n_out.red_out        = n_res[0];
        n_out.green_out      = n_res[1];
        n_out.blue_out       = n_res[2];
        n_out.alpha_out      = n_res[3];
        n_out.last_pixel_out = r_hi.last;
        n_emit               = w_adv && r_hv;
    end

    // ------------------------------------------------------------------
    // Output register with skid entry: a word leaving the pipeline goes to
    // the output register when it is free or being taken, else to the skid.
    // ------------------------------------------------------------------
    rda_pkg::t_out r_out;
    rda_pkg::t_out r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid  <= r_skid_valid || n_emit;
            r_skid_valid <= 1'b0;
        end else if (n_emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : n_out;
        end else if (n_emit) begin
            r_skid <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/rda_checker.sv -----
// ----------------------------------------------------------------------------
// RGBA density accumulator port checker
// Watches the top-level ports for flow-control slips.
// ----------------------------------------------------------------------------
`include "rgba_density_accumulator_defines.svh"

module rda_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input rda_pkg::t_out o_out_data
);

    // A stalled output word holds.
    `RDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // Input back-pressure only follows an output stall.
    `RDA_ASSERT_NOW(a_ready_low_cause, i_clk, i_rst_n, !o_in_ready, $past(o_out_valid && !i_out_ready))

    // A full skid entry means the output register is full too.
    `RDA_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, !o_in_ready, o_out_valid)

    // Reset empties the output side and opens the input.
    `RDA_ASSERT_RESET(a_reset_state, i_clk, i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind rgba_density_accumulator rda_checker u_rda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/tb_rgba_density_accumulator.sv -----
// ----------------------------------------------------------------------------
// RGBA density accumulator testbench
// Streams premultiplied pixel words through the accumulator under a series of
// density settings and checks every adjusted word, field by field, against a
// local fixed-point predictor. Both channels idle at random; the receiver
// also holds off for long stretches so the pipeline fills and backs up.
// ----------------------------------------------------------------------------
module tb_rgba_density_accumulator;

    // Fixed-point scales used by the predictor.
    localparam logic [63:0] UNIT       = 64'(rda_pkg::CH_ONE);
    localparam logic [63:0] UNIT_HALF  = 64'(rda_pkg::CH_ONE) >> 1;
    localparam logic [63:0] FRAC_UNIT  = 64'(rda_pkg::FRAC_ONE);
    localparam logic [63:0] WEIGHT_ONE = 64'(rda_pkg::REF_ONE);
    localparam int          LAYER_CAP  = rda_pkg::MAX_WHOLE_DEF;

    // Pipeline depth plus some slack, for draining before a register write
    // and at the end of the run.
    localparam int DRAIN_CYCLES = 2 * rda_pkg::MAX_WHOLE_DEF + 4 + 16;
    // Long receiver hold-off, well beyond pipeline depth plus skid entry.
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    // Pixels still queued when a hold-off starts, so the input backs up.
    localparam int HOLD_BACKLOG = 60;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    rda_pkg::t_in                   i_in_data  = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    rda_pkg::t_out                  o_out_data;
    logic                           i_cfg_we   = 1'b0;
    logic [rda_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = rda_pkg::CFG_DENSITY_WHOLE;
    logic [rda_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of the density registers, loaded with the reset values.
    logic [rda_pkg::WHOLE_REG_W-1:0] density_layers = 5'd1;
    logic [rda_pkg::FRAC_BITS-1:0]   density_frac   = '0;
    logic                            blend_on       = 1'b0;

    rda_pkg::t_in  pixel_queue[$];      // pixels waiting to be offered
    rda_pkg::t_out adjusted_words[$];   // predicted words not yet seen on the output
    int   mismatches = 0;
    int   words_seen = 0;
    int   next_hold  = 150;

    rgba_density_accumulator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // One layer: round(acc * t / ONE) + v, saturated at ONE.
    function automatic logic [63:0] add_layer(input logic [63:0] acc,
                                              input logic [63:0] v,
                                              input logic [63:0] trans);
        logic [63:0] n;
        n = (acc * trans + UNIT_HALF) / UNIT + v;
        return (n > UNIT) ? UNIT : n;
    endfunction

    // Adjust one channel of a pixel under the current density registers.
    function automatic rda_pkg::t_chan shade(input rda_pkg::t_chan chan,
                                             input rda_pkg::t_chan alpha,
                                             input logic [rda_pkg::REF_BITS-1:0] weight);
        logic [63:0] v;
        logic [63:0] trans;
        logic [63:0] f;
        logic [63:0] w;
        logic [63:0] acc;
        logic [63:0] nxt;
        int          layers;
        v      = 64'(chan);
        trans  = UNIT - 64'(alpha);
        f      = 64'(density_frac);
        w      = 64'(weight);
        // Whole part above the pipeline depth counts as the full depth.
        layers = (int'(density_layers) > LAYER_CAP) ? LAYER_CAP : int'(density_layers);
        acc    = v;
        if (layers >= 1) begin
            for (int i = 1; i < layers; i++) begin
                acc = add_layer(acc, v, trans);
            end
            // Blend one more layer in by the fraction.
            if (f != 0) begin
                nxt = add_layer(acc, v, trans);
                acc = (acc * (FRAC_UNIT - f) + nxt * f + (FRAC_UNIT >> 1)) / FRAC_UNIT;
            end
        end else if (f != 0) begin
            // No whole layer: scale the value by the fraction alone.
            acc = (v * f + (FRAC_UNIT >> 1)) / FRAC_UNIT;
        end else begin
            acc = '0;
        end
        if (acc > UNIT) begin
            acc = UNIT;
        end
        // Pull the result back toward the input by the reference weight.
        if (blend_on) begin
            acc = (v * (WEIGHT_ONE - w) + acc * w + (WEIGHT_ONE >> 1)) / WEIGHT_ONE;
            if (acc > UNIT) begin
                acc = UNIT;
            end
        end
        return acc[rda_pkg::CH_BITS-1:0];
    endfunction

    // Idle cycles before the next word; runs of zero come in bursts.
    function automatic int unsigned draw_gap(inout int unsigned burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued pixels, predict each word at its handshake
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_driver
        int unsigned  send_gap;
        int unsigned  send_burst;
        rda_pkg::t_in px;
        if (i_rst_n) begin
            px = i_in_data;
            if (i_in_valid && o_in_ready) begin
                adjusted_words.push_back(rda_pkg::t_out'{
                    red_out:        shade(px.red_in,   px.alpha_in, px.ref_weight),
                    green_out:      shade(px.green_in, px.alpha_in, px.ref_weight),
                    blue_out:       shade(px.blue_in,  px.alpha_in, px.ref_weight),
                    alpha_out:      shade(px.alpha_in, px.alpha_in, px.ref_weight),
                    last_pixel_out: px.last_pixel
                });
                send_gap = draw_gap(send_burst);
            end
            // Hold valid and payload until accepted; then idle or advance.
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    i_in_data  <= pixel_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted word, drive ready with random stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : word_monitor
        int unsigned   take_gap;
        int unsigned   take_burst;
        int unsigned   hold_left;
        rda_pkg::t_out want;
        rda_pkg::t_out got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (adjusted_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected word: r=%h g=%h b=%h a=%h last=%b",
                                 got.red_out, got.green_out, got.blue_out,
                                 got.alpha_out, got.last_pixel_out);
                    end
                end else begin
                    want = adjusted_words.pop_front();
                    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                        got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out ||
                        got.last_pixel_out !== want.last_pixel_out) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("word %0d mismatch: expected r=%h g=%h b=%h a=%h last=%b",
                                     words_seen, want.red_out, want.green_out,
                                     want.blue_out, want.alpha_out, want.last_pixel_out);
                            $display("word %0d mismatch: actual   r=%h g=%h b=%h a=%h last=%b",
                                     words_seen, got.red_out, got.green_out,
                                     got.blue_out, got.alpha_out, got.last_pixel_out);
                        end
                    end
                end
                words_seen++;
                take_gap = draw_gap(take_burst);
                // Now and then stall for a long stretch while the sender still
                // has plenty queued, so the pipeline backs up and drops o_in_ready.
                if (words_seen >= next_hold && pixel_queue.size() > HOLD_BACKLOG) begin
                    hold_left = HOLD_CYCLES;
                    next_hold = words_seen + 600;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Write one register at the next edge and track it in the local copy.
    task automatic write_reg(input rda_pkg::t_cfg_idx idx,
                             input logic [rda_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            rda_pkg::CFG_DENSITY_WHOLE:    density_layers = data[rda_pkg::WHOLE_REG_W-1:0];
            rda_pkg::CFG_DENSITY_FRACTION: density_frac   = data[rda_pkg::FRAC_BITS-1:0];
            rda_pkg::CFG_REF_ENABLE:       blend_on       = data[0];
            default: ;
        endcase
    endtask

    // Program all three registers; unused upper data bits carry junk.
    task automatic set_density(input logic [rda_pkg::WHOLE_REG_W-1:0] whole,
                               input logic [rda_pkg::FRAC_BITS-1:0] frac, input logic en);
        write_reg(rda_pkg::CFG_DENSITY_WHOLE,
                  {(rda_pkg::CFG_DATA_W-rda_pkg::WHOLE_REG_W)'($urandom), whole});
        write_reg(rda_pkg::CFG_DENSITY_FRACTION, frac);
        write_reg(rda_pkg::CFG_REF_ENABLE, {(rda_pkg::CFG_DATA_W-1)'($urandom), en});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input rda_pkg::t_chan r, input rda_pkg::t_chan g,
                              input rda_pkg::t_chan b, input rda_pkg::t_chan a,
                              input logic [rda_pkg::REF_BITS-1:0] w,
                              input logic last);
        pixel_queue.push_back(rda_pkg::t_in'{red_in: r, green_in: g, blue_in: b,
                                             alpha_in: a, ref_weight: w, last_pixel: last});
    endtask

    // Channel value biased toward the edges of the range.
    function automatic rda_pkg::t_chan pick_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return rda_pkg::CH_ONE;
            2:       return rda_pkg::t_chan'($urandom_range(1, 255));
            3:       return rda_pkg::CH_ONE - rda_pkg::t_chan'($urandom_range(1, 255));
            default: return rda_pkg::t_chan'($urandom);
        endcase
    endfunction

    // Edge cases: range limits, fully transparent and opaque alpha,
    // colour above alpha, weight limits, alternating bit patterns.
    task automatic push_directed();
        push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        push_pixel(16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'h0000, 1'b0);
        push_pixel(16'h8000, 16'h4000, 16'h1000, 16'h8000, 16'h8000, 1'b0);
        push_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0001, 1'b1);
        push_pixel(16'h1234, 16'hFFFF, 16'h0000, 16'h2000, 16'hFFFE, 1'b0);
        push_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        push_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        push_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        push_pixel(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'hFFFF, 1'b0);
        push_pixel(16'hFFFE, 16'h00FF, 16'hFF00, 16'hFFFE, 16'h0001, 1'b1);
    endtask

    // Mostly proper premultiplied pixels (colour at or below alpha);
    // the rest take any colour at all.
    task automatic push_random(input int count);
        rda_pkg::t_chan a;
        for (int i = 0; i < count; i++) begin
            a = pick_chan();
            if ($urandom_range(0, 3) != 0) begin
                push_pixel(rda_pkg::t_chan'($urandom_range(0, a)),
                           rda_pkg::t_chan'($urandom_range(0, a)),
                           rda_pkg::t_chan'($urandom_range(0, a)), a, pick_chan(),
                           $urandom_range(0, 15) == 0);
            end else begin
                push_pixel(pick_chan(), pick_chan(), pick_chan(), a, pick_chan(),
                           $urandom_range(0, 15) == 0);
            end
        end
    endtask

    // Wait until every pixel has been accepted and every word checked, then
    // let the pipeline settle before the next register write.
    task automatic drain();
        @(negedge i_clk);
        while (pixel_queue.size() > 0 || i_in_valid || adjusted_words.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Settings per fixed phase: no layers at all, fraction only, full
    // depth, whole parts above the depth limit, smallest fraction, etc.
    localparam int FIXED_PHASES = 8;
    localparam logic [rda_pkg::WHOLE_REG_W-1:0] PHASE_WHOLE [FIXED_PHASES] =
        '{5'd0, 5'd0, 5'd16, 5'd31, 5'd17, 5'd1, 5'd2, 5'd5};
    localparam logic [rda_pkg::FRAC_BITS-1:0] PHASE_FRAC [FIXED_PHASES] =
        '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h3039, 16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
    localparam logic PHASE_BLEND [FIXED_PHASES] =
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Edge cases under the reset settings, then with layering and blend.
        push_directed();
        drain();
        set_density(5'd3, 16'h8000, 1'b1);
        push_directed();
        drain();

        for (int p = 0; p < FIXED_PHASES + 4; p++) begin
            if (p < FIXED_PHASES) begin
                set_density(PHASE_WHOLE[p], PHASE_FRAC[p], PHASE_BLEND[p]);
            end else begin
                set_density(rda_pkg::WHOLE_REG_W'($urandom), pick_chan(), 1'($urandom));
            end
            @(negedge i_clk);
            push_random($urandom_range(100, 140));
            drain();
        end

        if (mismatches == 0 && adjusted_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/rda_pkg.sv
src/rgba_density_accumulator.sv
src/rda_checker.sv
tb/tb_rgba_density_accumulator.sv
